/* rtl/bmpd_pkg.sv */
// bmpd_pkg: shared types and constants for the bmp stream pixel decoder
// no dependencies
package bmpd_pkg;

  localparam logic [2:0] KIND_PIXEL = 3'd0;
  localparam logic [2:0] KIND_BAD_SIG = 3'd1;
  localparam logic [2:0] KIND_BAD_FMT = 3'd2;
  localparam logic [2:0] KIND_BAD_DIM = 3'd3;
  localparam logic [2:0] KIND_TRUNC = 3'd4;
  localparam logic [2:0] KIND_MASK_POS = 3'd5;

  localparam logic [31:0] DEF_RED = 32'h00FF0000;
  localparam logic [31:0] DEF_GREEN = 32'h0000FF00;
  localparam logic [31:0] DEF_BLUE = 32'h000000FF;
  localparam logic [31:0] DEF_ALPHA = 32'hFF000000;

  typedef struct packed {
    logic [31:0] mask;
    logic [4:0] low_bit;
    logic [7:0] mult;
    logic [4:0] post_shift;
  } chan_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] argb;
    logic last_pixel;
  } result_t;

  // scale factors for a run of mask bits
  function automatic chan_t chan_setup(logic [31:0] mask);
    chan_t c;
    logic [4:0] s;
    logic [5:0] bits;
    logic [31:0] m;
    logic found;
    c.mask = mask;
    s = '0;
    found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!found && mask[i]) begin
        s = 5'(i);
        found = 1'b1;
      end
    end
    m = mask >> s;
    // count trailing ones of the shifted mask
    bits = 6'd32;
    found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (!found && !m[i]) begin
        bits = 6'(i);
        found = 1'b1;
      end
    end
    c.low_bit = s;
    if (mask == '0) begin
      c.low_bit = '0;
      c.mult = '0;
      c.post_shift = '0;
    end else if (bits >= 6'd8) begin
      c.mult = 8'd1;
      c.post_shift = 5'(bits - 6'd8);
    end else begin
      case (bits[2:0])
        3'd1: c.mult = 8'd255;
        3'd2: c.mult = 8'd85;
        3'd3: c.mult = 8'd36;
        3'd4: c.mult = 8'd17;
        3'd5: c.mult = 8'd8;
        3'd6: c.mult = 8'd4;
        3'd7: c.mult = 8'd2;
        default: c.mult = 8'd0;
      endcase
      c.post_shift = '0;
    end
    return c;
  endfunction

endpackage

/* rtl/bmpd_scale.sv */
// bmpd_scale: normalizes one bitfield channel of a pixel to 8 bits
// depends on bmpd_pkg
module bmpd_scale (
  input  bmpd_pkg::chan_t chan_i,
  input  logic [31:0]     px_i,
  output logic [7:0]      val_o
);
  logic [31:0] field;
  logic [39:0] prod;
  logic [39:0] shifted;

  always_comb begin
    field = (px_i & chan_i.mask) >> chan_i.low_bit;
    // multiplier is 1 whenever the field is wider than 8 bits
    prod = (chan_i.mult == 8'd1) ? {8'd0, field} : 40'(field[7:0] * chan_i.mult);
    shifted = prod >> chan_i.post_shift;
    val_o = (chan_i.mask == '0) ? 8'd0 : shifted[7:0];
  end
endmodule

/* rtl/bmp_stream_pixel_decoder.sv */
// bmp_stream_pixel_decoder: top level, byte parser and result register
// depends on bmpd_pkg, bmpd_scale
//
// channel | dir | tdata                       | tuser | tlast
// s_axis  | in  | file_byte                   | -     | end_of_file
// m_axis  | out | kind,pixel_x,pixel_y,argb   | -     | last_pixel
//
// one byte per cycle while s_axis_tready is high; the parse state updates in the accept cycle
// a result is valid in the cycle after its byte is accepted, held in one output register
// s_axis_tready is high while the output register is empty or being taken
// reset clears parse state and output valid; after end of file state returns
// to its reset values for the next file
module bmp_stream_pixel_decoder #(
  parameter int unsigned MAX_DIM = 4096,
  parameter int unsigned MAX_PIXELS = 16777216
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [2:0] kind, [14:3] x, [26:15] y, [58:27] argb
  output logic        m_axis_tlast
);
  typedef enum logic [2:0] {
    PH_HEADER, PH_GAP, PH_PIXELS, PH_DONE, PH_ERROR
  } phase_e;

  phase_e phase_q, phase_d;
  logic [31:0] pos_q, pos_d, start_q, start_d, hsize_q, hsize_d, wbuf_q, wbuf_d;
  logic [12:0] width_q, width_d, height_q, height_d, col_q, col_d, row_q, row_d;
  logic topdown_q, topdown_d, four_q, four_d, bitf_q, bitf_d;
  bmpd_pkg::chan_t ch_q [4];
  bmpd_pkg::chan_t ch_d [4];
  logic [31:0] acc_q, acc_d;
  logic [1:0] bip_q, bip_d, pad_q, pad_d;
  bmpd_pkg::result_t res_q, res_d;
  logic out_v_q, out_v_d;
  logic [7:0] sc [4];
  logic [31:0] argb_px;

  logic acc_in;
  assign s_axis_tready = !out_v_q || m_axis_tready;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  logic [31:0] px_full;
  assign px_full = acc_q | ({24'd0, s_axis_tdata} << {bip_q, 3'd0});

  for (genvar g = 0; g < 4; g++) begin : g_scale
    bmpd_scale u_scale (.chan_i(ch_q[g]), .px_i(px_full), .val_o(sc[g]));
  end

  always_comb begin
    logic [31:0] w, h, base, rel;
    logic [32:0] st;
    logic [2:0] kind;
    logic pix, last;
    logic [11:0] px_x, px_y;
    logic [2:0] nb;
    logic [15:0] rowbytes;
    phase_d = phase_q; pos_d = pos_q; start_d = start_q; hsize_d = hsize_q;
    wbuf_d = wbuf_q; width_d = width_q; height_d = height_q; col_d = col_q;
    row_d = row_q; topdown_d = topdown_q; four_d = four_q; bitf_d = bitf_q;
    ch_d = ch_q; acc_d = acc_q; bip_d = bip_q; pad_d = pad_q;
    kind = bmpd_pkg::KIND_PIXEL; pix = 1'b0; last = 1'b0; px_x = '0; px_y = '0;
    argb_px = '0; w = '0; h = '0; base = '0; rel = '0; st = '0;
    nb = four_q ? 3'd4 : 3'd3;
    rowbytes = 16'(width_q) * 16'(nb);
    if (acc_in) begin
      if (pos_q != 32'hFFFFFFFF) pos_d = pos_q + 32'd1;
      if (phase_q == PH_HEADER || phase_q == PH_GAP)
        wbuf_d = {s_axis_tdata, wbuf_q[31:8]};
      w = wbuf_d;
      if (phase_q == PH_GAP && pos_q >= start_q) phase_d = PH_PIXELS;
      base = (hsize_q >= 32'd56) ? 32'd54 : 32'd14 + hsize_q;
      if (phase_q == PH_HEADER) begin
        case (pos_q)
          32'd0: if (s_axis_tdata != 8'h42) kind = bmpd_pkg::KIND_BAD_SIG;
          32'd1: if (s_axis_tdata != 8'h4D) kind = bmpd_pkg::KIND_BAD_SIG;
          32'd13: start_d = w;
          32'd17: begin
            hsize_d = w;
            if (w < 32'd40) kind = bmpd_pkg::KIND_BAD_FMT;
            else begin
              st = 33'd14 + 33'(w);
              if (33'(start_q) > st) st = 33'(start_q);
              start_d = st[32] ? 32'hFFFFFFFF : st[31:0];
            end
          end
          32'd21: begin
            if (w == '0 || w > 32'(MAX_DIM)) kind = bmpd_pkg::KIND_BAD_DIM;
            else width_d = w[12:0];
          end
          32'd25: begin
            h = w;
            if (w[31]) begin
              topdown_d = 1'b1;
              h = 32'd0 - w;
            end
            if (h == '0 || h > 32'(MAX_DIM)) kind = bmpd_pkg::KIND_BAD_DIM;
            else if (26'(width_q) * 26'(h[12:0]) > 26'(MAX_PIXELS))
              kind = bmpd_pkg::KIND_BAD_DIM;
            else height_d = h[12:0];
          end
          32'd27: if (w[31:16] != 16'd1) kind = bmpd_pkg::KIND_BAD_FMT;
          32'd29: begin
            if (w[31:16] != 16'd24 && w[31:16] != 16'd32) kind = bmpd_pkg::KIND_BAD_FMT;
            else four_d = (w[31:16] == 16'd32);
          end
          32'd33: begin
            if (w != 32'd0 && w != 32'd3) kind = bmpd_pkg::KIND_BAD_FMT;
            else if (w == 32'd3 && !four_q) kind = bmpd_pkg::KIND_BAD_FMT;
            else begin
              bitf_d = (w == 32'd3);
              if (w == 32'd3 && (33'(base) + 33'd12 > 33'(start_q)))
                kind = bmpd_pkg::KIND_MASK_POS;
              else begin
                if (w == 32'd3) ch_d[3] = bmpd_pkg::chan_setup('0);
                phase_d = PH_GAP;
              end
            end
          end
          default: ;
        endcase
      end else if (phase_d == PH_GAP) begin
        if (bitf_q) begin
          if (pos_q >= base) begin
            rel = pos_q - base;
            if (rel == 32'd3) ch_d[0] = bmpd_pkg::chan_setup(w);
            else if (rel == 32'd7) ch_d[1] = bmpd_pkg::chan_setup(w);
            else if (rel == 32'd11) begin
              ch_d[2] = bmpd_pkg::chan_setup(w);
              if (ch_q[0].mask == '0 || ch_q[1].mask == '0 || w == '0)
                kind = bmpd_pkg::KIND_BAD_FMT;
            end
          end
          if (hsize_q >= 32'd56 && pos_q == 32'd69) ch_d[3] = bmpd_pkg::chan_setup(w);
        end
      end else if (phase_d == PH_PIXELS) begin
        if (pad_q != 2'd0) begin
          pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0 && row_q >= height_q) phase_d = PH_DONE;
        end else begin
          acc_d = px_full;
          if (3'(bip_q) + 3'd1 >= nb) begin
            if (!four_q) argb_px = {8'hFF, px_full[23:0]};
            else if (!bitf_q) argb_px = px_full;
            else argb_px = {(ch_q[3].mask != '0) ? sc[3] : 8'hFF, sc[0], sc[1], sc[2]};
            pix = 1'b1;
            px_x = col_q[11:0];
            px_y = topdown_q ? row_q[11:0] : 12'(height_q - 13'd1 - row_q);
            last = (row_q + 13'd1 == height_q) && (col_q + 13'd1 == width_q);
            acc_d = '0;
            bip_d = '0;
            col_d = col_q + 13'd1;
            if (col_d >= width_q) begin
              col_d = '0;
              row_d = row_q + 13'd1;
              pad_d = 2'(3'd4 - {1'b0, rowbytes[1:0]});
              if (pad_d == 2'd0 && row_d >= height_q) phase_d = PH_DONE;
            end
          end else begin
            bip_d = bip_q + 2'd1;
          end
        end
      end
      if (kind != bmpd_pkg::KIND_PIXEL) phase_d = PH_ERROR;
      if (s_axis_tlast && kind == bmpd_pkg::KIND_PIXEL && phase_d != PH_DONE
          && phase_d != PH_ERROR) begin
        kind = bmpd_pkg::KIND_TRUNC;
        pix = 1'b0;
      end
      if (s_axis_tlast) begin
        phase_d = PH_HEADER; pos_d = '0; start_d = '0; hsize_d = '0; width_d = '0;
        height_d = '0; wbuf_d = '0; acc_d = '0; topdown_d = 1'b0; four_d = 1'b0;
        bitf_d = 1'b0; bip_d = '0; col_d = '0; row_d = '0; pad_d = '0;
        ch_d[0] = '{mask: bmpd_pkg::DEF_RED, default: '0};
        ch_d[1] = '{mask: bmpd_pkg::DEF_GREEN, default: '0};
        ch_d[2] = '{mask: bmpd_pkg::DEF_BLUE, default: '0};
        ch_d[3] = '{mask: bmpd_pkg::DEF_ALPHA, default: '0};
      end
    end
    res_d = res_q;
    out_v_d = out_v_q && !m_axis_tready;
    if (acc_in && kind != bmpd_pkg::KIND_PIXEL) begin
      out_v_d = 1'b1;
      res_d = '{kind: kind, default: '0};
    end else if (acc_in && pix) begin
      out_v_d = 1'b1;
      res_d = '{kind: bmpd_pkg::KIND_PIXEL, pixel_x: px_x, pixel_y: px_y,
                argb: argb_px, last_pixel: last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; pos_q <= '0; start_q <= '0; hsize_q <= '0;
      wbuf_q <= '0; width_q <= '0; height_q <= '0; col_q <= '0; row_q <= '0;
      topdown_q <= 1'b0; four_q <= 1'b0; bitf_q <= 1'b0; acc_q <= '0;
      bip_q <= '0; pad_q <= '0; out_v_q <= 1'b0;
      ch_q[0] <= '{mask: bmpd_pkg::DEF_RED, default: '0};
      ch_q[1] <= '{mask: bmpd_pkg::DEF_GREEN, default: '0};
      ch_q[2] <= '{mask: bmpd_pkg::DEF_BLUE, default: '0};
      ch_q[3] <= '{mask: bmpd_pkg::DEF_ALPHA, default: '0};
    end else begin
      phase_q <= phase_d; pos_q <= pos_d; start_q <= start_d; hsize_q <= hsize_d;
      wbuf_q <= wbuf_d; width_q <= width_d; height_q <= height_d; col_q <= col_d;
      row_q <= row_d; topdown_q <= topdown_d; four_q <= four_d; bitf_q <= bitf_d;
      acc_q <= acc_d; bip_q <= bip_d; pad_q <= pad_d; out_v_q <= out_v_d;
      ch_q <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {5'd0, res_q.argb, res_q.pixel_y, res_q.pixel_x, res_q.kind};
  assign m_axis_tlast = res_q.last_pixel;
endmodule

/* rtl/bmpd_checker.sv */
// bmpd_checker: port-level assertions for the decoder
// depends on bmpd_pkg and the bmp_stream_pixel_decoder ports
module bmpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  // a waiting result is held
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // input stalls only when output is full and blocked
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without cause");
  // error results carry zero payload
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != bmpd_pkg::KIND_PIXEL |->
      m_axis_tdata[63:3] == '0 && !m_axis_tlast)
    else $error("error result with payload");
  // kind stays in range
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= bmpd_pkg::KIND_MASK_POS)
    else $error("kind out of range");
endmodule

bind bmp_stream_pixel_decoder bmpd_checker u_bmpd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
  .m_axis_tlast(m_axis_tlast)
);
